// ===== design/rcqc_pkg.sv =====
// shared types and constants of the consensus quality caller
package rcqc_pkg;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int TABLE_LEN = 22;
   localparam logic [7:0] TERM_OTHER_OFS = 8'd76;
   localparam logic [6:0] QUAL_OFS = 7'd33;
   localparam logic [6:0] QUAL_MAX = 7'd75;
   localparam logic [6:0] COUNT_OFS = 7'd32;
   localparam logic [6:0] COUNT_CHAR_MAX = 7'd126;
   localparam logic [6:0] COUNT_MAX = 7'd127;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_QRY1  = 4'b0100,
      ST_QRY2  = 4'b1000
   } state_type;

   function automatic logic [6:0] one_minus_p(input logic [4:0] q);
      logic [6:0] r;
      case (q)
         5'd1: r = 7'd110;  5'd2: r = 7'd69;  5'd3: r = 7'd48;  5'd4: r = 7'd35;
         5'd5: r = 7'd26;   5'd6: r = 7'd20;  5'd7: r = 7'd15;  5'd8: r = 7'd12;
         5'd9: r = 7'd9;    5'd10: r = 7'd7;  5'd11: r = 7'd6;  5'd12: r = 7'd5;
         5'd13: r = 7'd4;   5'd14: r = 7'd3;  5'd15: r = 7'd2;  5'd16: r = 7'd2;
         5'd17: r = 7'd1;   5'd18: r = 7'd1;  5'd19: r = 7'd1;  5'd20: r = 7'd1;
         5'd21: r = 7'd1;
         default: r = 7'd0;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] lse(input logic [4:0] k);
      logic [5:0] r;
      case (k)
         5'd0: r = 6'd48;  5'd1: r = 6'd41;  5'd2: r = 6'd34;  5'd3: r = 6'd28;
         5'd4: r = 6'd23;  5'd5: r = 6'd19;  5'd6: r = 6'd16;  5'd7: r = 6'd13;
         5'd8: r = 6'd10;  5'd9: r = 6'd8;   5'd10: r = 6'd7;  5'd11: r = 6'd5;
         5'd12: r = 6'd4;  5'd13: r = 6'd3;  5'd14: r = 6'd3;  5'd15: r = 6'd2;
         5'd16: r = 6'd2;  5'd17: r = 6'd1;  5'd18: r = 6'd1;  5'd19: r = 6'd1;
         5'd20: r = 6'd1;  5'd21: r = 6'd1;
         default: r = 6'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] letter(input logic [1:0] b);
      logic [7:0] r;
      case (b)
         2'd0: r = 8'h41;
         2'd1: r = 8'h43;
         2'd2: r = 8'h47;
         default: r = 8'h54;
      endcase
      return r;
   endfunction

endpackage

// ===== design/read_consensus_quality_caller_unit.sv =====
// per-position consensus base caller with quality, store in one memory
//
// channel  dir  ports
// req      in   req_valid req_ready req_cmd req_position req_base_char req_qual_char
// rsp      out  rsp_valid rsp_ready rsp_valid_res rsp_cons_base rsp_count_char rsp_cons_qual
//
// an add reads its entry, then writes it back from stage 1; a forwarding register
// lets a following add on the same position use the new entry, so adds stream at
// one per cycle while no query or response is pending. a query steps through read
// and pick, combine and finish, and is taken only with a free output register.
// reset and clear sweep the memory, one position a cycle, with req_ready low.
module read_consensus_quality_caller_unit #(
   parameter int MAX_POSITIONS = 256,
   parameter int SCORE_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_position,
   input  logic [7:0] req_base_char,
   input  logic [6:0] req_qual_char,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_valid_res,
   output logic [7:0] rsp_cons_base,
   output logic [6:0] rsp_count_char,
   output logic [6:0] rsp_cons_qual
);

   localparam int AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
   localparam int LW = AW + 1;
   localparam int EW = 4 * (7 + SCORE_BITS);
   localparam logic [SCORE_BITS-1:0] SMAX = {SCORE_BITS{1'b1}};

   typedef logic [SCORE_BITS-1:0] score_type;

   logic [EW-1:0] mem [MAX_POSITIONS];

   rcqc_pkg::state_type state_ff, state_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [LW-1:0] len_ff, len_in;

   // stage 1 registers (an add or a query whose memory read is under way)
   logic          s1_add_ff, s1_add_in, s1_qry_ff, s1_qry_in;
   logic [AW-1:0] s1_pos_ff;
   logic [1:0]    s1_bin_ff;
   logic [SCORE_BITS-1:0] s1_called_ff, s1_other_ff;
   logic [EW-1:0] rd_ff;
   // last written entry for forwarding
   logic          fw_ok_ff, fw_ok_in;
   logic [AW-1:0] fw_pos_ff;
   logic [EW-1:0] fw_data_ff;
   // query pipeline
   logic          q_inval_ff;
   logic [1:0]    q_best_ff;
   logic [6:0]    q_cnt_ff;
   score_type     q_oth_ff, q_bs_ff;
   score_type     q_oa_ff, q_ob_ff, q_oc_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_vr_ff;
   logic [7:0] rsp_base_ff;
   logic [6:0] rsp_cnt_ff, rsp_qual_ff;

   function automatic score_type comb2(input score_type a, input score_type b);
      score_type lo, d;
      logic [5:0] f;
      lo = (a < b) ? a : b;
      d = (a < b) ? b - a : a - b;
      f = ((d >> 4) < score_type'(rcqc_pkg::TABLE_LEN)) ?
          rcqc_pkg::lse(d[8:4]) : 6'd0;
      return (lo > score_type'(f)) ? lo - score_type'(f) : '0;
   endfunction

   // request decode
   logic acc, is_add, base_ok, pos_ok;
   logic [1:0] bin;
   logic [6:0] q7;
   logic [AW-1:0] pos_a;
   always_comb begin
      acc = req_valid && req_ready;
      case (req_base_char)
         8'h41: begin bin = 2'd0; base_ok = 1'b1; end
         8'h43: begin bin = 2'd1; base_ok = 1'b1; end
         8'h47: begin bin = 2'd2; base_ok = 1'b1; end
         8'h54: begin bin = 2'd3; base_ok = 1'b1; end
         default: begin bin = 2'd0; base_ok = 1'b0; end
      endcase
      pos_ok = 32'(req_position) < MAX_POSITIONS;
      pos_a = AW'(req_position);
      is_add = req_cmd == rcqc_pkg::CMD_ADD && base_ok && pos_ok;
      q7 = (req_qual_char < rcqc_pkg::QUAL_OFS) ? 7'd0 : req_qual_char - rcqc_pkg::QUAL_OFS;
   end

   // add write-back of stage 1
   logic [EW-1:0] cur, wr_data;
   always_comb begin
      cur = (fw_ok_ff && fw_pos_ff == s1_pos_ff) ? fw_data_ff : rd_ff;
      for (int j = 0; j < 4; j++) begin
         logic [6:0] c;
         logic [SCORE_BITS:0] s;
         c = cur[j*(7+SCORE_BITS) + SCORE_BITS +: 7];
         s = {1'b0, cur[j*(7+SCORE_BITS) +: SCORE_BITS]} +
             {1'b0, (j == 32'(s1_bin_ff)) ? s1_called_ff : s1_other_ff};
         if (j == 32'(s1_bin_ff) && c != rcqc_pkg::COUNT_MAX) c = c + 7'd1;
         wr_data[j*(7+SCORE_BITS) +: 7+SCORE_BITS] =
            {c, s[SCORE_BITS] ? SMAX : s[SCORE_BITS-1:0]};
      end
   end

   // query stage: pick best, gather others in bin order
   score_type sc [4];
   logic [6:0] cn [4];
   logic [1:0] best;
   score_type oa, ob, oc;
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         sc[j] = cur[j*(7+SCORE_BITS) +: SCORE_BITS];
         cn[j] = cur[j*(7+SCORE_BITS) + SCORE_BITS +: 7];
      end
      best = 2'd0;
      for (int j = 1; j < 4; j++)
         if (sc[j] < sc[best]) best = 2'(j);
      case (best)
         2'd0: begin oa = sc[1]; ob = sc[2]; oc = sc[3]; end
         2'd1: begin oa = sc[0]; ob = sc[2]; oc = sc[3]; end
         2'd2: begin oa = sc[0]; ob = sc[1]; oc = sc[3]; end
         default: begin oa = sc[0]; ob = sc[1]; oc = sc[2]; end
      endcase
   end

   // share of the other bins against the total
   score_type q_qd;
   assign q_qd = q_oth_ff - comb2(q_oth_ff, q_bs_ff);

   logic qry_busy;
   assign qry_busy = s1_qry_ff || state_ff == rcqc_pkg::ST_QRY1 ||
                     state_ff == rcqc_pkg::ST_QRY2;
   assign req_ready = state_ff == rcqc_pkg::ST_IDLE && !qry_busy && !rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      len_in = len_ff;
      s1_add_in = acc && is_add;
      s1_qry_in = acc && req_cmd == rcqc_pkg::CMD_QUERY;
      fw_ok_in = s1_add_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         rcqc_pkg::ST_CLEAR: begin
            sweep_in = sweep_ff + AW'(1);
            fw_ok_in = 1'b0;
            if (32'(sweep_ff) == MAX_POSITIONS - 1) state_in = rcqc_pkg::ST_IDLE;
         end
         rcqc_pkg::ST_IDLE: begin
            if (acc && req_cmd == rcqc_pkg::CMD_CLEAR) begin
               state_in = rcqc_pkg::ST_CLEAR;
               sweep_in = '0;
               len_in = '0;
            end
            if (acc && is_add && LW'(req_position) >= len_ff)
               len_in = LW'(req_position) + LW'(1);
            if (s1_qry_ff) state_in = rcqc_pkg::ST_QRY1;
         end
         rcqc_pkg::ST_QRY1: state_in = rcqc_pkg::ST_QRY2;
         rcqc_pkg::ST_QRY2: begin
            state_in = rcqc_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: state_in = rcqc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcqc_pkg::ST_CLEAR;
         sweep_ff <= '0;
         len_ff <= '0;
         s1_add_ff <= 1'b0;
         s1_qry_ff <= 1'b0;
         fw_ok_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         len_ff <= len_in;
         s1_add_ff <= s1_add_in;
         s1_qry_ff <= s1_qry_in;
         fw_ok_ff <= fw_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // memory
   always_ff @(posedge clock) begin
      if (state_ff == rcqc_pkg::ST_CLEAR) mem[sweep_ff] <= '0;
      else if (s1_add_ff) mem[s1_pos_ff] <= wr_data;
      rd_ff <= mem[pos_a];
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_pos_ff <= pos_a;
         s1_bin_ff <= bin;
         q_inval_ff <= !(pos_ok && LW'(req_position) < len_ff);
         if (q7 == 7'd0) s1_called_ff <= SMAX;
         else s1_called_ff <= SCORE_BITS'(rcqc_pkg::one_minus_p(q7[4:0] & {5{q7 < 7'd22}}));
         s1_other_ff <= SCORE_BITS'({q7, 4'd0}) + SCORE_BITS'(rcqc_pkg::TERM_OTHER_OFS);
      end
      if (s1_add_ff) begin
         fw_pos_ff <= s1_pos_ff;
         fw_data_ff <= wr_data;
      end
      if (s1_qry_ff) begin
         q_best_ff <= best;
         q_cnt_ff <= cn[best];
         q_bs_ff <= sc[best];
         q_oa_ff <= oa;
         q_ob_ff <= ob;
         q_oc_ff <= oc;
      end
      if (state_ff == rcqc_pkg::ST_QRY1) q_oth_ff <= comb2(comb2(q_oa_ff, q_ob_ff), q_oc_ff);
      if (state_ff == rcqc_pkg::ST_QRY2) begin
         rsp_vr_ff <= !q_inval_ff;
         rsp_base_ff <= q_inval_ff ? 8'd0 : rcqc_pkg::letter(q_best_ff);
         rsp_cnt_ff <= q_inval_ff ? 7'd0 :
            ((q_cnt_ff > 7'd94) ? rcqc_pkg::COUNT_CHAR_MAX : q_cnt_ff + rcqc_pkg::COUNT_OFS);
         rsp_qual_ff <= q_inval_ff ? 7'd0 :
            ((q_qd >> 4) > score_type'(42) ? rcqc_pkg::QUAL_MAX :
             7'(q_qd >> 4) + rcqc_pkg::QUAL_OFS);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_valid_res = rsp_vr_ff;
   assign rsp_cons_base = rsp_base_ff;
   assign rsp_count_char = rsp_cnt_ff;
   assign rsp_cons_qual = rsp_qual_ff;

endmodule
